>>> hw/rtl/fsc_pkg.sv
// ============================================================================
// fsc_pkg: shared definitions for the frustum sphere cull unit
// Register indexes, reset values, pipeline depth and the verdict encoding.
// ============================================================================
`default_nettype none

package fsc_pkg;

   // Number of register stages between an accepted transaction and its result.
   localparam int PIPE_STAGES = 6;

   // Configuration register indexes (byte address is 8 * index).
   localparam logic [2:0] REG_CAMERA_POSITION = 3'd0;
   localparam logic [2:0] REG_RIGHT_AXIS      = 3'd1;
   localparam logic [2:0] REG_UP_AXIS         = 3'd2;
   localparam logic [2:0] REG_VIEW_AXIS       = 3'd3;
   localparam logic [2:0] REG_NEAR_DISTANCE   = 3'd4;
   localparam logic [2:0] REG_FAR_DISTANCE    = 3'd5;
   localparam logic [2:0] REG_TANGENT_PAIR    = 3'd6;
   localparam logic [2:0] REG_SPHERE_FACTORS  = 3'd7;

   // The far distance resets to its largest value; all other registers to zero.
   localparam logic [21:0] FAR_DISTANCE_RESET = 22'h3F_FFFF;

   // Classification of one sphere.
   typedef enum logic [1:0] {
      VERDICT_INSIDE     = 2'd0,
      VERDICT_INTERSECTS = 2'd1,
      VERDICT_OUTSIDE    = 2'd2
   } verdict_type;

endpackage

`default_nettype wire

>>> hw/rtl/frustum_sphere_cull_unit.sv
// ============================================================================
// frustum_sphere_cull_unit: sphere against view frustum classifier
// Classifies a sphere as inside, intersecting or outside a camera-radar
// frustum, using fixed-point dot products against the programmed camera axes.
// ============================================================================
//
//  Channel   Ports                                   Transfer
//  --------  --------------------------------------  ----------------------------
//  request   start, busy, req_center_*, req_sphere_  start high while busy low
//  result    rsp_strobe, rsp_verdict                 one cycle per strobe
//  config    psel, penable, pwrite, paddr, pwdata,   setup + access, pready = 1
//            prdata, pready
//
//  Each transaction passes from acceptance to its result strobe through the six
//  register stages: offset, axis products, dot sums, frustum limits, bounds,
//  verdict. A new transaction may be accepted in every cycle, so busy
//  is always low. Reset clears the valid bits of all stages and loads the
//  register reset values. The receiver cannot stall, so nothing holds the
//  pipeline.
//
`default_nettype none

module frustum_sphere_cull_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [20:0] req_center_x,
   input  wire logic signed [20:0] req_center_y,
   input  wire logic signed [20:0] req_center_z,
   input  wire logic [19:0]        req_sphere_radius,
   // Result channel
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_verdict,
   // Configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [5:0]         paddr,
   input  wire logic [63:0]        pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);

   // Configuration registers.
   logic [62:0] camera_ff;
   logic [59:0] right_ff;
   logic [59:0] up_ff;
   logic [59:0] view_ff;
   logic [21:0] near_ff;
   logic [21:0] far_ff;
   logic [47:0] tangent_ff;
   logic [47:0] factor_ff;

   logic        cfg_write;
   logic [2:0]  cfg_index;
   logic        accept;

   // Pipeline valid bits, one per stage.
   logic [fsc_pkg::PIPE_STAGES-1:0] valid_ff;
   logic [fsc_pkg::PIPE_STAGES-1:0] valid_in;

   // Stage 1: offsets from the camera.
   logic signed [21:0] off_ff [3];
   logic [19:0]        rad1_ff;

   // Stage 2: axis products (axis 0 view, 1 up, 2 right) and radius factors.
   logic signed [41:0] prod_ff [3][3];
   logic [43:0]        dv2_ff;
   logic [43:0]        dh2_ff;
   logic [19:0]        rad2_ff;

   // Stage 3: floored dot products in Q.8.
   logic signed [29:0] dot_ff [3];
   logic [43:0]        dv3_ff;
   logic [43:0]        dh3_ff;
   logic [19:0]        rad3_ff;

   // Stage 4: depth verdict and lateral limits.
   fsc_pkg::verdict_type depth_ff;
   logic signed [54:0]   limv_ff;
   logic signed [54:0]   limh_ff;
   logic signed [29:0]   ay4_ff;
   logic signed [29:0]   ax4_ff;
   logic [43:0]          dv4_ff;
   logic [43:0]          dh4_ff;

   // Stage 5: lateral bounds in Q.24.
   fsc_pkg::verdict_type depth5_ff;
   logic signed [57:0]   v_out_hi_ff, v_out_lo_ff, v_int_hi_ff, v_int_lo_ff;
   logic signed [57:0]   h_out_hi_ff, h_out_lo_ff, h_int_hi_ff, h_int_lo_ff;
   logic signed [57:0]   ay5_ff;
   logic signed [57:0]   ax5_ff;

   // Stage 6: final verdict.
   fsc_pkg::verdict_type verdict_ff;
   fsc_pkg::verdict_type verdict_in;

   // Combinational intermediates.
   logic signed [20:0]   cam_comp [3];
   logic signed [20:0]   center [3];
   logic signed [19:0]   axis_comp [3][3];
   logic signed [43:0]   dot_sum [3];
   logic signed [31:0]   az32, far32, near32, rad32;
   logic                 depth_out, depth_int;
   fsc_pkg::verdict_type depth_in;
   logic signed [57:0]   limv58, limh58, dv58, dh58;
   logic                 v_out, v_int, h_out, h_int;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------

   // A write completes in the access cycle of the transaction.
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_ff  <= '0;
         right_ff   <= '0;
         up_ff      <= '0;
         view_ff    <= '0;
         near_ff    <= '0;
         far_ff     <= fsc_pkg::FAR_DISTANCE_RESET;
         tangent_ff <= '0;
         factor_ff  <= '0;
      end else if (cfg_write) begin
         case (cfg_index)
            fsc_pkg::REG_CAMERA_POSITION: camera_ff  <= pwdata[62:0];
            fsc_pkg::REG_RIGHT_AXIS:      right_ff   <= pwdata[59:0];
            fsc_pkg::REG_UP_AXIS:         up_ff      <= pwdata[59:0];
            fsc_pkg::REG_VIEW_AXIS:       view_ff    <= pwdata[59:0];
            fsc_pkg::REG_NEAR_DISTANCE:   near_ff    <= pwdata[21:0];
            fsc_pkg::REG_FAR_DISTANCE:    far_ff     <= pwdata[21:0];
            fsc_pkg::REG_TANGENT_PAIR:    tangent_ff <= pwdata[47:0];
            fsc_pkg::REG_SPHERE_FACTORS:  factor_ff  <= pwdata[47:0];
            default: ;
         endcase
      end
   end

   // Read data is the selected register, zero extended.
   always_comb begin
      case (cfg_index)
         fsc_pkg::REG_CAMERA_POSITION: prdata = {1'b0, camera_ff};
         fsc_pkg::REG_RIGHT_AXIS:      prdata = {4'b0, right_ff};
         fsc_pkg::REG_UP_AXIS:         prdata = {4'b0, up_ff};
         fsc_pkg::REG_VIEW_AXIS:       prdata = {4'b0, view_ff};
         fsc_pkg::REG_NEAR_DISTANCE:   prdata = {42'b0, near_ff};
         fsc_pkg::REG_FAR_DISTANCE:    prdata = {42'b0, far_ff};
         fsc_pkg::REG_TANGENT_PAIR:    prdata = {16'b0, tangent_ff};
         fsc_pkg::REG_SPHERE_FACTORS:  prdata = {16'b0, factor_ff};
         default:                      prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Valid bits travel with the data through every stage.
   // ------------------------------------------------------------------------

   assign valid_in = {valid_ff[fsc_pkg::PIPE_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Unpack the camera position and axis components.
   always_comb begin
      center[0] = req_center_x;
      center[1] = req_center_y;
      center[2] = req_center_z;
      for (int i = 0; i < 3; i++) begin
         cam_comp[i]     = $signed(camera_ff[21*i +: 21]);
         axis_comp[0][i] = $signed(view_ff[20*i +: 20]);
         axis_comp[1][i] = $signed(up_ff[20*i +: 20]);
         axis_comp[2][i] = $signed(right_ff[20*i +: 20]);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: offset of the center from the camera, exact in 22 bits.
   // ------------------------------------------------------------------------

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         off_ff[i] <= 22'(center[i]) - 22'(cam_comp[i]);
      end
      rad1_ff <= req_sphere_radius;
   end

   // ------------------------------------------------------------------------
   // Stage 2: the nine axis products and the two radius factor products.
   // ------------------------------------------------------------------------

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[a][i] <= off_ff[i] * axis_comp[a][i];
         end
      end
      dv2_ff  <= factor_ff[23:0] * rad1_ff;
      dh2_ff  <= factor_ff[47:24] * rad1_ff;
      rad2_ff <= rad1_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 3: dot products in Q.22, floored to Q.8 by an arithmetic shift.
   // ------------------------------------------------------------------------

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dot_sum[a] = 44'(prod_ff[a][0]) + 44'(prod_ff[a][1]) + 44'(prod_ff[a][2]);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         dot_ff[a] <= dot_sum[a][43:14];
      end
      dv3_ff  <= dv2_ff;
      dh3_ff  <= dh2_ff;
      rad3_ff <= rad2_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 4: depth test against near and far, and the lateral limits.
   // ------------------------------------------------------------------------

   always_comb begin
      az32   = 32'(dot_ff[0]);
      far32  = $signed({6'b0, far_ff, 4'b0});
      near32 = $signed({6'b0, near_ff, 4'b0});
      rad32  = $signed({8'b0, rad3_ff, 4'b0});

      depth_out = (az32 > far32 + rad32) || (az32 < near32 - rad32);
      depth_int = (az32 > far32 - rad32) || (az32 < near32 + rad32);

      if (depth_out) begin
         depth_in = fsc_pkg::VERDICT_OUTSIDE;
      end else if (depth_int) begin
         depth_in = fsc_pkg::VERDICT_INTERSECTS;
      end else begin
         depth_in = fsc_pkg::VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff <= depth_in;
      limv_ff  <= dot_ff[0] * $signed({1'b0, tangent_ff[23:0]});
      limh_ff  <= dot_ff[0] * $signed({1'b0, tangent_ff[47:24]});
      ay4_ff   <= dot_ff[1];
      ax4_ff   <= dot_ff[2];
      dv4_ff   <= dv3_ff;
      dh4_ff   <= dh3_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 5: outside and intersect bounds for both lateral tests, in Q.24.
   // ------------------------------------------------------------------------

   always_comb begin
      limv58 = 58'(limv_ff);
      limh58 = 58'(limh_ff);
      dv58   = $signed({10'b0, dv4_ff, 4'b0});
      dh58   = $signed({10'b0, dh4_ff, 4'b0});
   end

   always_ff @(posedge clock) begin
      depth5_ff   <= depth_ff;
      v_out_hi_ff <= limv58 + dv58;
      v_out_lo_ff <= -limv58 - dv58;
      v_int_hi_ff <= limv58 - dv58;
      v_int_lo_ff <= dv58 - limv58;
      h_out_hi_ff <= limh58 + dh58;
      h_out_lo_ff <= -limh58 - dh58;
      h_int_hi_ff <= limh58 - dh58;
      h_int_lo_ff <= dh58 - limh58;
      ay5_ff      <= 58'($signed({ay4_ff, 16'b0}));
      ax5_ff      <= 58'($signed({ax4_ff, 16'b0}));
   end

   // ------------------------------------------------------------------------
   // Stage 6: combine the three tests; any outside wins, then any intersect.
   // ------------------------------------------------------------------------

   always_comb begin
      v_out = (ay5_ff > v_out_hi_ff) || (ay5_ff < v_out_lo_ff);
      v_int = (ay5_ff > v_int_hi_ff) || (ay5_ff < v_int_lo_ff);
      h_out = (ax5_ff > h_out_hi_ff) || (ax5_ff < h_out_lo_ff);
      h_int = (ax5_ff > h_int_hi_ff) || (ax5_ff < h_int_lo_ff);

      if ((depth5_ff == fsc_pkg::VERDICT_OUTSIDE) || v_out || h_out) begin
         verdict_in = fsc_pkg::VERDICT_OUTSIDE;
      end else if ((depth5_ff == fsc_pkg::VERDICT_INTERSECTS) || v_int || h_int) begin
         verdict_in = fsc_pkg::VERDICT_INTERSECTS;
      end else begin
         verdict_in = fsc_pkg::VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_strobe  = valid_ff[fsc_pkg::PIPE_STAGES-1];
   assign rsp_verdict = verdict_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Every accepted transaction yields its result strobe after the last stage.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_strobe)
      else $error("result strobe missing for an accepted transaction");

   // No result appears without a matching accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 6))
      else $error("result strobe without an accepted transaction");

   // A point test never reports an intersection.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_sphere_radius == '0)) |->
         ##6 (rsp_verdict != fsc_pkg::VERDICT_INTERSECTS))
      else $error("point test reported an intersection");

   // A sphere outside in depth leaves the pipeline as outside.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && (depth_ff == fsc_pkg::VERDICT_OUTSIDE)) |->
         ##2 (rsp_strobe && (rsp_verdict == fsc_pkg::VERDICT_OUTSIDE)))
      else $error("depth outside verdict lost in the lateral stages");

endmodule

`default_nettype wire
